/* rtl/four_level_page_table_walker_defines.svh */
// Assertion macros shared by the page table walker RTL.
// Included by the controller and the datapath; depends on nothing else.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked at every rising edge outside reset
`define PTW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("page table walker check failed");
// property checked at every rising edge, reset included
`define PTW_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("page table walker check failed");
`else
`define PTW_ASSERT(lbl, clk, rst, prop)
`define PTW_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/ptw_pkg.sv */
// Shared types, constants and helpers of the page table walker.
// Used by the table RAM, the controller, the datapath and the top level.
`default_nettype none

package ptw_pkg;

   // sizes
   localparam int NUM_TABLE_FRAMES  = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = 9;
   localparam int OFFSET_W          = 12;
   localparam int ENTRY_W           = 64;
   localparam int VA_W              = 48;
   localparam int PA_W              = 52;
   localparam int FLAGS_W           = 12;
   localparam int ROOT_W            = 6;
   localparam int ACTION_W          = 2;
   localparam int FRAME_FIELD_W     = ENTRY_W - OFFSET_W;

   // virtual address index positions per level
   localparam int SHIFT_L0 = 39;
   localparam int SHIFT_L1 = 30;
   localparam int SHIFT_L2 = 21;
   localparam int SHIFT_L3 = 12;

   // request codes
   localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MAP       = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_UNMAP     = 2'd2;

   // walk levels
   localparam logic [1:0] LEVEL_TOP      = 2'd0;
   localparam logic [1:0] LEVEL_DIR_LAST = 2'd2;
   localparam logic [1:0] LEVEL_LEAF     = 2'd3;

   // flags of an intermediate entry: present, write, user
   localparam logic [OFFSET_W-1:0] TABLE_FLAGS = 12'h007;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_CHECK,
      ST_SIZE,
      ST_LEAF,
      ST_DONE
   } ptw_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic start_walk;
      logic rd_en;
      logic advance;
      logic alloc_wr;
      logic leaf_wr;
      logic set_need;
      logic set_hit;
      logic set_fail;
      logic rsp_load;
   } ptw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [1:0]          level;
      logic                root_bad;
      logic                present;
      logic                bad_frame;
      logic                need_fits;
      logic                alloc_avail;
      logic                clear_last;
   } ptw_status_type;

   // 9-bit table index of a walk level
   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [1:0] level);
      logic [IDX_W-1:0] idx;
      case (level)
         2'd0:    idx = va[SHIFT_L0 +: IDX_W];
         2'd1:    idx = va[SHIFT_L1 +: IDX_W];
         2'd2:    idx = va[SHIFT_L2 +: IDX_W];
         default: idx = va[SHIFT_L3 +: IDX_W];
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

/* rtl/ptw_table_ram.sv */
// Table memory of the walker: one write port, one registered read port.
// Each word is a 64-bit entry plus the allocation mark of its frame at write time.
`default_nettype none

module ptw_table_ram #(
   parameter int NUM_TABLE_FRAMES = ptw_pkg::NUM_TABLE_FRAMES
) (
   input  wire logic                                                  clock,
   input  wire logic                                                  wr_en,
   input  wire logic [$clog2(NUM_TABLE_FRAMES)+ptw_pkg::IDX_W-1:0]   wr_addr,
   input  wire logic [ptw_pkg::ENTRY_W:0]                            wr_data,
   input  wire logic                                                  rd_en,
   input  wire logic [$clog2(NUM_TABLE_FRAMES)+ptw_pkg::IDX_W-1:0]   rd_addr,
   output logic      [ptw_pkg::ENTRY_W:0]                            rd_data
);
   localparam int DEPTH  = NUM_TABLE_FRAMES * ptw_pkg::ENTRIES_PER_TABLE;
   localparam int DATA_W = ptw_pkg::ENTRY_W + 1;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/ptw_ctrl.sv */
// Sequencer of the walker: reset clearing pass, walk, allocation and response.
// Uses ptw_pkg types; drives the datapath by command, reads its status.
`default_nettype none

`include "four_level_page_table_walker_defines.svh"

module ptw_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire ptw_pkg::ptw_status_type status,
   output ptw_pkg::ptw_cmd_type         cmd
);
   ptw_pkg::ptw_state_type state_ff, state_in;
   logic pass2_ff, pass2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic walk_ok;
   logic rsp_free;

   assign walk_ok    = status.present && !status.bad_frame;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ptw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptw_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = ptw_pkg::ST_IDLE;
         end
         ptw_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ptw_pkg::ST_START;
         end
         ptw_pkg::ST_START: begin
            if (!(status.action inside {ptw_pkg::ACT_TRANSLATE, ptw_pkg::ACT_MAP,
                                        ptw_pkg::ACT_UNMAP}) || status.root_bad) begin
               state_in = ptw_pkg::ST_DONE;
            end else begin
               state_in = ptw_pkg::ST_READ;
            end
         end
         ptw_pkg::ST_READ: state_in = ptw_pkg::ST_CHECK;
         ptw_pkg::ST_CHECK: begin
            case (status.action)
               ptw_pkg::ACT_TRANSLATE: begin
                  if (status.level != ptw_pkg::LEVEL_LEAF && walk_ok) begin
                     state_in = ptw_pkg::ST_READ;
                  end else begin
                     state_in = ptw_pkg::ST_DONE;
                  end
               end
               ptw_pkg::ACT_UNMAP: begin
                  if (!walk_ok) state_in = ptw_pkg::ST_DONE;
                  else if (status.level == ptw_pkg::LEVEL_DIR_LAST) state_in = ptw_pkg::ST_LEAF;
                  else state_in = ptw_pkg::ST_READ;
               end
               ptw_pkg::ACT_MAP: begin
                  if (!pass2_ff) begin
                     if (status.present && status.bad_frame) state_in = ptw_pkg::ST_DONE;
                     else if (status.present && status.level != ptw_pkg::LEVEL_DIR_LAST) begin
                        state_in = ptw_pkg::ST_READ;
                     end else state_in = ptw_pkg::ST_SIZE;
                  end else if (walk_ok || (!status.present && status.alloc_avail)) begin
                     if (status.level == ptw_pkg::LEVEL_DIR_LAST) state_in = ptw_pkg::ST_LEAF;
                     else state_in = ptw_pkg::ST_READ;
                  end else begin
                     state_in = ptw_pkg::ST_DONE;
                  end
               end
               default: state_in = ptw_pkg::ST_DONE;
            endcase
         end
         ptw_pkg::ST_SIZE: begin
            state_in = status.need_fits ? ptw_pkg::ST_READ : ptw_pkg::ST_DONE;
         end
         ptw_pkg::ST_LEAF: state_in = ptw_pkg::ST_DONE;
         ptw_pkg::ST_DONE: begin
            if (rsp_free) state_in = ptw_pkg::ST_IDLE;
         end
         default: state_in = ptw_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      pass2_in     = pass2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ptw_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
         ptw_pkg::ST_IDLE: begin
            cmd.load_req = req_tvalid;
            if (req_tvalid) pass2_in = 1'b0;
         end
         ptw_pkg::ST_START: begin
            cmd.set_fail = (status.action == ptw_pkg::ACT_MAP) && status.root_bad;
         end
         ptw_pkg::ST_READ: cmd.rd_en = 1'b1;
         ptw_pkg::ST_CHECK: begin
            case (status.action)
               ptw_pkg::ACT_TRANSLATE: begin
                  if (status.level == ptw_pkg::LEVEL_LEAF) cmd.set_hit = status.present;
                  else cmd.advance = walk_ok;
               end
               ptw_pkg::ACT_UNMAP: cmd.advance = walk_ok;
               ptw_pkg::ACT_MAP: begin
                  if (!pass2_ff) begin
                     // first pass: count the tables still missing
                     if (status.present && status.bad_frame) cmd.set_fail = 1'b1;
                     else if (status.present && status.level != ptw_pkg::LEVEL_DIR_LAST) begin
                        cmd.advance = 1'b1;
                     end else cmd.set_need = 1'b1;
                  end else begin
                     // second pass: follow or allocate
                     if (walk_ok) cmd.advance = 1'b1;
                     else if (!status.present && status.alloc_avail) cmd.alloc_wr = 1'b1;
                     else cmd.set_fail = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ptw_pkg::ST_SIZE: begin
            if (status.need_fits) begin
               cmd.start_walk = 1'b1;
               pass2_in       = 1'b1;
            end else begin
               cmd.set_fail = 1'b1;
            end
         end
         ptw_pkg::ST_LEAF: cmd.leaf_wr = 1'b1;
         ptw_pkg::ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptw_pkg::ST_CLEAR;
         pass2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass2_ff     <= pass2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `PTW_ASSERT(a_accept_starts, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ptw_pkg::ST_START))
   `PTW_ASSERT(a_held_rsp_waits, clock, reset, (state_ff == ptw_pkg::ST_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == ptw_pkg::ST_DONE))
   `PTW_ASSERT(a_pass2_map_only, clock, reset, pass2_ff |-> (status.action == ptw_pkg::ACT_MAP))

endmodule

`default_nettype wire

/* rtl/ptw_datapath.sv */
// Datapath of the walker: request and config registers, frame allocator,
// entry decode, table RAM port muxing and result registers. Uses ptw_pkg.
`default_nettype none

`include "four_level_page_table_walker_defines.svh"

module ptw_datapath #(
   parameter int NUM_TABLE_FRAMES = ptw_pkg::NUM_TABLE_FRAMES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ptw_pkg::ptw_cmd_type               cmd,
   output ptw_pkg::ptw_status_type                 status,
   input  wire logic [ptw_pkg::ACTION_W-1:0]      req_action,
   input  wire logic [ptw_pkg::VA_W-1:0]          req_virt_addr,
   input  wire logic [ptw_pkg::PA_W-1:0]          req_phys_addr,
   input  wire logic [ptw_pkg::FLAGS_W-1:0]       req_entry_flags,
   input  wire logic                              csr_wr_en,
   input  wire logic [ptw_pkg::ROOT_W-1:0]        csr_wr_data,
   output logic                                   mem_wr_en,
   output logic [$clog2(NUM_TABLE_FRAMES)+ptw_pkg::IDX_W-1:0] mem_wr_addr,
   output logic      [ptw_pkg::ENTRY_W:0]         mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [$clog2(NUM_TABLE_FRAMES)+ptw_pkg::IDX_W-1:0] mem_rd_addr,
   input  wire logic [ptw_pkg::ENTRY_W:0]         mem_rd_data,
   output logic      [ptw_pkg::PA_W-1:0]          rsp_translated_addr,
   output logic                                   rsp_hit,
   output logic                                   rsp_out_of_frames
);
   localparam int FW    = $clog2(NUM_TABLE_FRAMES);
   localparam int NFW   = $clog2(NUM_TABLE_FRAMES + 1);
   localparam int AW    = FW + ptw_pkg::IDX_W;
   localparam int FFW   = ptw_pkg::FRAME_FIELD_W;
   localparam int DEPTH = NUM_TABLE_FRAMES * ptw_pkg::ENTRIES_PER_TABLE;
   localparam logic [AW-1:0]  CLEAR_LAST = AW'(DEPTH - 1);
   localparam logic [NFW-1:0] NUM_FR     = NFW'(NUM_TABLE_FRAMES);

   // registers
   logic [ptw_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [ptw_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [ptw_pkg::VA_W-1:0]     va_ff, va_in;
   logic [ptw_pkg::PA_W-1:0]     pa_ff, pa_in;
   logic [ptw_pkg::FLAGS_W-1:0]  flags_ff, flags_in;
   logic [FW-1:0]                cur_ff, cur_in;
   logic [1:0]                   level_ff, level_in;
   logic [NFW-1:0]               nff_ff, nff_in;
   logic [1:0]                   need_ff, need_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [ptw_pkg::PA_W-1:0]     res_addr_ff, res_addr_in;
   logic                         res_hit_ff, res_hit_in;
   logic                         res_oof_ff, res_oof_in;
   logic [ptw_pkg::PA_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic                         rsp_oof_ff, rsp_oof_in;

   // decode
   logic [ptw_pkg::IDX_W-1:0]   idx;
   logic [AW-1:0]               slot_addr;
   logic                        cur_allocated;
   logic [ptw_pkg::ENTRY_W-1:0] entry;
   logic [ptw_pkg::ENTRY_W-1:0] leaf_value;

   assign idx           = ptw_pkg::level_index(va_ff, level_ff);
   assign slot_addr     = {cur_ff, idx};
   assign cur_allocated = NFW'(cur_ff) < nff_ff;

   // an entry written under the other allocation state of its frame reads as zero
   assign entry = (mem_rd_data[ptw_pkg::ENTRY_W] == cur_allocated) ?
                  mem_rd_data[ptw_pkg::ENTRY_W-1:0] : '0;

   assign leaf_value = (action_ff == ptw_pkg::ACT_MAP) ?
      {12'd0, pa_ff[ptw_pkg::PA_W-1:ptw_pkg::OFFSET_W], flags_ff} : '0;

   // status
   always_comb begin
      status.action      = action_ff;
      status.level       = level_ff;
      status.root_bad    = int'(root_ff) >= NUM_TABLE_FRAMES;
      status.present     = entry[0];
      status.bad_frame   = entry[ptw_pkg::ENTRY_W-1:ptw_pkg::OFFSET_W] >=
                           FFW'(NUM_TABLE_FRAMES);
      status.need_fits   = NFW'(need_ff) <= (NUM_FR - nff_ff);
      status.alloc_avail = nff_ff < NUM_FR;
      status.clear_last  = clr_ff == CLEAR_LAST;
   end

   // table RAM ports
   always_comb begin
      mem_wr_en   = cmd.clear_wr || cmd.alloc_wr || cmd.leaf_wr;
      mem_wr_addr = cmd.clear_wr ? clr_ff : slot_addr;
      if (cmd.clear_wr) begin
         mem_wr_data = '0;
      end else if (cmd.alloc_wr) begin
         // frame of the slot is marked against the allocator after this step
         mem_wr_data = {NFW'(cur_ff) <= nff_ff, FFW'(nff_ff),
                        ptw_pkg::TABLE_FLAGS};
      end else begin
         mem_wr_data = {cur_allocated, leaf_value};
      end
      mem_rd_en   = cmd.rd_en;
      mem_rd_addr = slot_addr;
   end

   // next values
   always_comb begin
      root_in     = csr_wr_en ? csr_wr_data : root_ff;
      action_in   = action_ff;
      va_in       = va_ff;
      pa_in       = pa_ff;
      flags_in    = flags_ff;
      cur_in      = cur_ff;
      level_in    = level_ff;
      nff_in      = nff_ff;
      need_in     = need_ff;
      clr_in      = cmd.clear_wr ? clr_ff + AW'(1) : clr_ff;
      res_addr_in = res_addr_ff;
      res_hit_in  = res_hit_ff;
      res_oof_in  = res_oof_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_oof_in  = rsp_oof_ff;

      // request capture
      if (cmd.load_req) begin
         action_in   = req_action;
         va_in       = req_virt_addr;
         pa_in       = req_phys_addr;
         flags_in    = req_entry_flags;
         res_addr_in = '0;
         res_hit_in  = 1'b0;
         res_oof_in  = 1'b0;
      end

      // walk position
      if (cmd.load_req || cmd.start_walk) begin
         cur_in   = FW'(root_ff);
         level_in = ptw_pkg::LEVEL_TOP;
      end else if (cmd.advance) begin
         cur_in   = entry[ptw_pkg::OFFSET_W +: FW];
         level_in = level_ff + 2'd1;
      end else if (cmd.alloc_wr) begin
         cur_in   = FW'(nff_ff);
         level_in = level_ff + 2'd1;
         nff_in   = nff_ff + NFW'(1);
      end

      // tables still missing below this level
      if (cmd.set_need) begin
         need_in = entry[0] ? 2'd0 : (ptw_pkg::LEVEL_LEAF - level_ff);
      end

      // results
      if (cmd.set_hit) begin
         res_addr_in = {entry[ptw_pkg::PA_W-1:ptw_pkg::OFFSET_W],
                        va_ff[ptw_pkg::OFFSET_W-1:0]};
         res_hit_in  = 1'b1;
      end
      if (cmd.set_fail) res_oof_in = 1'b1;
      if (cmd.rsp_load) begin
         rsp_addr_in = res_addr_ff;
         rsp_hit_in  = res_hit_ff;
         rsp_oof_in  = res_oof_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff  <= '0;
         nff_ff   <= NFW'(1);
         clr_ff   <= '0;
         level_ff <= ptw_pkg::LEVEL_TOP;
      end else begin
         root_ff  <= root_in;
         nff_ff   <= nff_in;
         clr_ff   <= clr_in;
         level_ff <= level_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      va_ff       <= va_in;
      pa_ff       <= pa_in;
      flags_ff    <= flags_in;
      cur_ff      <= cur_in;
      need_ff     <= need_in;
      res_addr_ff <= res_addr_in;
      res_hit_ff  <= res_hit_in;
      res_oof_ff  <= res_oof_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_oof_ff  <= rsp_oof_in;
   end

   assign rsp_translated_addr = rsp_addr_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_out_of_frames   = rsp_oof_ff;

   // checks
   `PTW_ASSERT(a_alloc_bound, clock, reset, nff_ff <= NUM_FR)
   `PTW_ASSERT(a_alloc_only_on_cmd, clock, reset, (!cmd.alloc_wr) |=> $stable(nff_ff))

endmodule

`default_nettype wire

/* rtl/four_level_page_table_walker.sv */
// Four-level page table walker. After reset the table memory is cleared, one
// entry per cycle, all NUM_TABLE_FRAMES*512 entries (32768 at the default size);
// no request is taken during that pass, while root_frame writes are. A request
// is then taken and its single response follows: map makes a counting walk,
// then a second walk that allocates; an undefined action or a root_frame beyond
// the table memory gets its response without a walk. Each table level passes
// through a read state and a check state because the walk goes through the one
// read port of the table RAM and its registered read. A finished response waits
// in an output register; the next request is taken while it waits. Depends on
// ptw_pkg, ptw_ctrl, ptw_datapath and ptw_table_ram.
`default_nettype none

module four_level_page_table_walker #(
   parameter int NUM_TABLE_FRAMES = ptw_pkg::NUM_TABLE_FRAMES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,   // virt_addr[47:0], phys_addr[99:48], entry_flags[111:100]
   input  wire logic [1:0]   req_tuser,   // action[1:0]
   // response stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [55:0]  rsp_tdata,   // translated_addr[51:0], zero[55:52]
   output logic      [1:0]   rsp_tuser,   // hit[0], out_of_frames[1]
   // root_frame register
   input  wire logic         csr_wr_en,
   input  wire logic [5:0]   csr_wr_data  // root_frame[5:0]
);
   localparam int FW = $clog2(NUM_TABLE_FRAMES);
   localparam int AW = FW + ptw_pkg::IDX_W;

   ptw_pkg::ptw_cmd_type    cmd;
   ptw_pkg::ptw_status_type status;

   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic [ptw_pkg::ENTRY_W:0]   mem_wr_data;
   logic                        mem_rd_en;
   logic [AW-1:0]               mem_rd_addr;
   logic [ptw_pkg::ENTRY_W:0]   mem_rd_data;
   logic [ptw_pkg::PA_W-1:0]    rsp_addr;
   logic                        rsp_hit;
   logic                        rsp_oof;

   // sequencer
   ptw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   ptw_datapath #(
      .NUM_TABLE_FRAMES (NUM_TABLE_FRAMES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_tuser),
      .req_virt_addr       (req_tdata[47:0]),
      .req_phys_addr       (req_tdata[99:48]),
      .req_entry_flags     (req_tdata[111:100]),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data),
      .rsp_translated_addr (rsp_addr),
      .rsp_hit             (rsp_hit),
      .rsp_out_of_frames   (rsp_oof)
   );

   // table memory
   ptw_table_ram #(
      .NUM_TABLE_FRAMES (NUM_TABLE_FRAMES)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {4'd0, rsp_addr};
   assign rsp_tuser = {rsp_oof, rsp_hit};

endmodule

`default_nettype wire
